FILE: rtl/dnat_pkg.sv
// Package for the dynamic NAT pool allocator: word types, verdict codes
// and configuration register indexes. No dependencies.
`timescale 1ns / 1ps
package dnat_pkg;

  typedef logic [1:0] verdict_t;
  localparam verdict_t V_PASS = 2'd0;
  localparam verdict_t V_HIT  = 2'd1;
  localparam verdict_t V_NEW  = 2'd2;
  localparam verdict_t V_DROP = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POOL_BASE_IP     = 2'd0;
  localparam cfg_idx_t CFG_POOL_SIZE_IN_USE = 2'd1;
  localparam cfg_idx_t CFG_IDLE_TIMEOUT     = 2'd2;

  typedef struct packed {
    logic        is_ipv4;
    logic [31:0] src_ip;
    logic [63:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] out_src_ip;
    logic [5:0]  slot_index;
    logic [6:0]  released_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] pool_base_ip;
    logic [6:0]  pool_size_in_use;
    logic [63:0] idle_timeout;
  } cfg_t;

endpackage

FILE: rtl/dnat_if.sv
// Valid/ready channel interfaces for packet words and result words.
// Depends on dnat_pkg.
`timescale 1ns / 1ps
interface dnat_in_if;
  import dnat_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface dnat_out_if;
  import dnat_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

FILE: rtl/dynamic_nat_pool_allocator.sv
// Top level of the dynamic source-NAT address pool allocator.
// Depends on dnat_pkg, dnat_if, dnat_ram, dnat_front and dnat_back.
//
//   channel   dir  handshake          word
//   pkt_in    in   valid/ready        is_ipv4, src_ip, now_ticks
//   pkt_out   out  valid/ready        verdict, out_src_ip, slot_index, released_count
//   cfg       in   cfg_we (no wait)   cfg_index, cfg_data
//
// A non-IPv4 word goes straight to the result. An IPv4 word is looked up
// until a hit or the last slot, and a miss then sweeps the active slots,
// as the engine reads the slot address and time memories one slot per cycle.
// Reset clears the slot marks at once, so no clearing pass is needed.
// A two-word queue takes input while the engine works, and the output
// register holds a result while the sink stalls.
`timescale 1ns / 1ps
module dynamic_nat_pool_allocator #(
  parameter int POOL_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  dnat_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]       cfg_data,
  dnat_in_if.sink           pkt_in,
  dnat_out_if.source        pkt_out
);
  import dnat_pkg::*;

  cfg_t cfg;

  // Configuration registers; a write to an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base_ip     <= 32'd0;
      cfg.pool_size_in_use <= 7'd64;
      cfg.idle_timeout     <= 64'd500000000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE_IP:     cfg.pool_base_ip     <= cfg_data[31:0];
        CFG_POOL_SIZE_IN_USE: cfg.pool_size_in_use <= cfg_data[6:0];
        CFG_IDLE_TIMEOUT:     cfg.idle_timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The queue between the front and the engine.
  dnat_in_if q_ch ();

  dnat_front u_front (
    .clk(clk), .rst(rst), .pkt_in(pkt_in), .q_out(q_ch.source)
  );

  dnat_back #(.POOL_SLOTS(POOL_SLOTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_in(q_ch.sink), .pkt_out(pkt_out)
  );
endmodule

FILE: rtl/dnat_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
module dnat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/dnat_front.sv
// Front part: accepts packet words into a two-entry queue for the engine.
// Depends on dnat_pkg and dnat_if.
`timescale 1ns / 1ps
module dnat_front (
  input  logic      clk,
  input  logic      rst,
  dnat_in_if.sink   pkt_in,
  dnat_in_if.source q_out
);
  import dnat_pkg::*;

  in_item_t   slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign pkt_in.ready = (cnt != 2'd2);
  assign q_out.valid  = (cnt != 2'd0);
  assign q_out.data   = slots[rp];
  assign push = pkt_in.valid && pkt_in.ready;
  assign pop  = q_out.valid && q_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= pkt_in.data;
  end
endmodule

FILE: rtl/dnat_back.sv
// Back part: slot lookup, idle sweep, binding and the result register.
// Depends on dnat_pkg, dnat_if and dnat_ram.
`timescale 1ns / 1ps
module dnat_back #(
  parameter int POOL_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  dnat_pkg::cfg_t cfg,
  dnat_in_if.sink        q_in,
  dnat_out_if.source     pkt_out
);
  import dnat_pkg::*;

  localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_BIND  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t    state;
  in_item_t  cur;
  out_item_t res;
  out_item_t out_d;
  logic      out_v;

  logic [POOL_SLOTS-1:0] in_use;
  logic          use_rd;
  logic [IW-1:0] idx;
  logic          iss_v;
  logic [IW-1:0] ck_idx;
  logic          ck_v;
  logic          found;
  logic [IW-1:0] pick;
  logic [CW-1:0] rel;

  logic [31:0] pip_rd;
  logic [63:0] ls_rd;
  logic        pip_we;
  logic        ls_we;
  logic [IW-1:0] ls_waddr;

  logic [CW-1:0] eff;
  logic [CW-1:0] eff_m1;
  logic [IW-1:0] last_act;
  logic [IW-1:0] last_slot;
  logic [63:0]   age;
  logic          hit_c;
  logic          idle_c;
  logic          free_c;
  logic [31:0]   ck32;
  logic [31:0]   pick32;
  logic [31:0]   rel32;

  assign eff = (32'(cfg.pool_size_in_use) > 32'(POOL_SLOTS)) ? CW'(POOL_SLOTS)
                                                           : CW'(cfg.pool_size_in_use);
  assign eff_m1    = eff - CW'(1);
  assign last_act  = eff_m1[IW-1:0];
  assign last_slot = IW'(POOL_SLOTS - 1);
  assign age    = cur.now_ticks - ls_rd;
  assign hit_c  = ck_v && use_rd && (pip_rd == cur.src_ip);
  assign idle_c = (age >= cfg.idle_timeout);
  assign free_c = !use_rd || idle_c;
  assign ck32   = 32'(ck_idx);
  assign pick32 = 32'(pick);
  assign rel32  = 32'(rel);

  assign pip_we   = (state == S_BIND) && found;
  assign ls_we    = ((state == S_LOOK) && hit_c) || pip_we;
  assign ls_waddr = (state == S_LOOK) ? ck_idx : pick;

  dnat_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_pip_ram (
    .clk(clk), .we(pip_we), .waddr(pick), .wdata(cur.src_ip),
    .raddr(idx), .rdata(pip_rd)
  );

  dnat_ram #(.WIDTH(64), .DEPTH(POOL_SLOTS)) u_ls_ram (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(cur.now_ticks),
    .raddr(idx), .rdata(ls_rd)
  );

  assign q_in.ready    = (state == S_IDLE);
  assign pkt_out.valid = out_v;
  assign pkt_out.data  = out_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      out_v  <= 1'b0;
      in_use <= '0;
      iss_v  <= 1'b0;
      ck_v   <= 1'b0;
      idx    <= '0;
      ck_idx <= '0;
      found  <= 1'b0;
      pick   <= '0;
      rel    <= '0;
    end else begin
      if (state == S_EMIT && (!out_v || pkt_out.ready)) out_v <= 1'b1;
      else if (out_v && pkt_out.ready) out_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_in.valid) begin
            idx   <= '0;
            iss_v <= 1'b1;
            ck_v  <= 1'b0;
            state <= q_in.data.is_ipv4 ? S_LOOK : S_EMIT;
          end
        end
        S_LOOK: begin
          ck_v <= iss_v;
          if (iss_v) begin
            ck_idx <= idx;
            idx    <= idx + IW'(1);
            iss_v  <= (idx != last_slot);
          end
          if (hit_c) begin
            state <= S_EMIT;
          end else if (ck_v && ck_idx == last_slot) begin
            found <= 1'b0;
            rel   <= '0;
            idx   <= '0;
            iss_v <= 1'b1;
            state <= (eff == '0) ? S_BIND : S_SWEEP;
          end
        end
        S_SWEEP: begin
          ck_v <= iss_v;
          if (iss_v) begin
            ck_idx <= idx;
            idx    <= idx + IW'(1);
            iss_v  <= (idx != last_act);
          end
          if (ck_v) begin
            if (use_rd && idle_c) begin
              in_use[ck_idx] <= 1'b0;
              rel <= rel + CW'(1);
            end
            if (free_c && !found) begin
              found <= 1'b1;
              pick  <= ck_idx;
            end
            if (ck_idx == last_act) state <= S_BIND;
          end
        end
        S_BIND: begin
          if (found) in_use[pick] <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_v || pkt_out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The slot mark is read in step with the two memories.
  always_ff @(posedge clk) begin
    use_rd <= in_use[idx];
  end

  // Payload: the current packet, the staged result and the output word.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_in.valid) begin
      cur <= q_in.data;
      res <= '{verdict: V_PASS, out_src_ip: q_in.data.src_ip, slot_index: 6'd0,
               released_count: 7'd0};
    end
    if (state == S_LOOK && hit_c) begin
      res <= '{verdict: V_HIT, out_src_ip: cfg.pool_base_ip + ck32,
               slot_index: ck32[5:0], released_count: 7'd0};
    end
    if (state == S_BIND) begin
      if (found) begin
        res <= '{verdict: V_NEW, out_src_ip: cfg.pool_base_ip + pick32,
                 slot_index: pick32[5:0], released_count: rel32[6:0]};
      end else begin
        res <= '{verdict: V_DROP, out_src_ip: cur.src_ip, slot_index: 6'd0,
                 released_count: rel32[6:0]};
      end
    end
    if (state == S_EMIT && (!out_v || pkt_out.ready)) out_d <= res;
  end

`ifndef SYNTHESIS
  // A refresh of an existing binding always ends the lookup.
  a_hit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && ls_we) |=> state == S_EMIT)
    else $error("hit did not end the lookup");

  // A new binding marks its slot as in use.
  a_bind_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIND && found) |=> in_use[$past(pick)])
    else $error("bound slot not marked in use");

  // Only a miss may release bindings.
  a_hit_no_rel: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (res.verdict == V_HIT || res.verdict == V_PASS))
      |-> res.released_count == 7'd0)
    else $error("release count on a hit or pass");
`endif
endmodule
